// ----- hw/rtl/lsvp_pkg.sv -----
// lsvp_pkg: shared constants, codes and control structs of the looping sample voice player
// used by lsvp_ctrl, lsvp_dpath, the top and the testbench; depends on nothing
package lsvp_pkg;

    localparam int SAMPLE_DEPTH = 4096;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int SAMPLE_W     = 16;
    localparam int POS_W        = 13;
    localparam int FRAC_W       = 32;
    localparam int CUR_W        = POS_W + FRAC_W;
    localparam int STEP_W       = 40;
    localparam int LOOP_W       = 12;
    localparam int PASS_W       = 16;
    localparam int GAIN_W       = 16;
    localparam int OUT_W        = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 40;

    localparam logic [STEP_W-1:0] STEP_RESET   = 40'h01_0000_0000;
    localparam logic [GAIN_W-1:0] MASTER_RESET = 16'h0040;
    localparam logic [PASS_W-1:0] PASS_MAX     = '1;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SIZE    = 3'd0,
        REG_FRAME_COUNT  = 3'd1,
        REG_LOOP_START   = 3'd2,
        REG_LOOP_LIMIT   = 3'd3,
        REG_GAIN_LEFT    = 3'd4,
        REG_GAIN_RIGHT   = 3'd5,
        REG_MASTER_LEFT  = 3'd6,
        REG_MASTER_RIGHT = 3'd7
    } t_reg_idx;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;      // capture item fields, clear outputs
        logic ram_we;     // write one sample
        logic start;      // place cursor, set active
        logic stop;       // clear active
        logic clr_active; // unplayable voice
        logic end_pass;   // one end crossing: wrap or finish
        logic show;       // shown position from cursor
        logic rd_cur;     // read current frame, latch fraction and next index, gains
        logic rd_nxt;     // read next frame, capture current, advance cursor
        logic mul;        // difference times fraction
        logic acc;        // add current frame
        logic scale;      // apply gains
        logic load_out;   // fill the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic active;
        logic can_play;
        logic past_end;
    } t_status;

endpackage

// ----- hw/rtl/lsvp_ram.sv -----
// lsvp_ram: generic single-port ram with registered read
// no dependencies
module lsvp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lsvp_ctrl.sv -----
// lsvp_ctrl: item sequencer of the voice player, one-hot state machine
// depends on lsvp_pkg
module lsvp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_kind,
    input  logic               i_out_ready,
    input  lsvp_pkg::t_status  i_status,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output lsvp_pkg::t_cmd     o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_WRITE  = 11'b000_0000_0010,
        S_START  = 11'b000_0000_0100,
        S_STOP   = 11'b000_0000_1000,
        S_SETTLE = 11'b000_0001_0000,
        S_RD_CUR = 11'b000_0010_0000,
        S_RD_NXT = 11'b000_0100_0000,
        S_MUL    = 11'b000_1000_0000,
        S_ACC    = 11'b001_0000_0000,
        S_SCALE  = 11'b010_0000_0000,
        S_FINISH = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_tick, n_tick;
    logic   r_second, n_second;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state  = r_state;
        n_tick   = r_tick;
        n_second = r_second;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    n_second    = 1'b0;
                    n_tick      = 1'b0;
                    case (lsvp_pkg::t_kind'(i_kind))
                        lsvp_pkg::KIND_WRITE: n_state = S_WRITE;
                        lsvp_pkg::KIND_START: n_state = S_START;
                        lsvp_pkg::KIND_STOP:  n_state = S_STOP;
                        lsvp_pkg::KIND_TICK: begin
                            n_state = S_SETTLE;
                            n_tick  = 1'b1;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.ram_we = 1'b1;
                n_state      = S_FINISH;
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_SETTLE;
            end
            S_STOP: begin
                o_cmd.stop = 1'b1;
                n_state    = S_FINISH;
            end
            S_SETTLE: begin
                if (!i_status.active) begin
                    n_state = S_FINISH;
                end else if (!i_status.can_play) begin
                    o_cmd.clr_active = 1'b1;
                    n_state          = S_FINISH;
                end else if (i_status.past_end) begin
                    o_cmd.end_pass = 1'b1;
                end else begin
                    o_cmd.show = 1'b1;
                    n_state    = (r_tick && !r_second) ? S_RD_CUR : S_FINISH;
                end
            end
            S_RD_CUR: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = S_RD_NXT;
            end
            S_RD_NXT: begin
                o_cmd.rd_nxt = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_second    = 1'b1;
                n_state     = S_SETTLE;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= 1'b0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- hw/rtl/lsvp_dpath.sv -----
// lsvp_dpath: voice datapath: config registers, cursor, sample store, interpolation and gain
// depends on lsvp_pkg and lsvp_ram
module lsvp_dpath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lsvp_pkg::t_cmd                        i_cmd,
    output lsvp_pkg::t_status                     o_status,
    input  logic                                  i_cfg_valid,
    input  logic [lsvp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lsvp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic [11:0]                           i_sample_address,
    input  logic signed [lsvp_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic [lsvp_pkg::POS_W-1:0]            i_start_position,
    output logic signed [lsvp_pkg::OUT_W-1:0]     o_left_out,
    output logic signed [lsvp_pkg::OUT_W-1:0]     o_right_out,
    output logic                                  o_is_playing,
    output logic [lsvp_pkg::POS_W-1:0]            o_frame_position,
    output logic [lsvp_pkg::PASS_W-1:0]           o_passes_done
);

    // configuration
    logic [lsvp_pkg::STEP_W-1:0] r_step;
    logic [lsvp_pkg::POS_W-1:0]  r_frame_count;
    logic [lsvp_pkg::LOOP_W-1:0] r_loop_start;
    logic [lsvp_pkg::PASS_W-1:0] r_loop_limit;
    logic [lsvp_pkg::GAIN_W-1:0] r_gain_l, r_gain_r, r_master_l, r_master_r;

    // voice state
    logic [lsvp_pkg::CUR_W-1:0]  r_cursor;
    logic                        r_active;
    logic [lsvp_pkg::PASS_W-1:0] r_pass;
    logic [lsvp_pkg::POS_W-1:0]  r_shown;

    // item fields and working registers
    logic [lsvp_pkg::ADDR_W-1:0]        r_addr;
    logic [lsvp_pkg::SAMPLE_W-1:0]      r_wdata;
    logic [lsvp_pkg::POS_W-1:0]         r_pos;
    logic [15:0]                        r_f;
    logic [lsvp_pkg::ADDR_W-1:0]        r_nxt;
    logic [lsvp_pkg::SAMPLE_W-1:0]      r_s0;
    logic [15:0]                        r_gl, r_gr;
    logic signed [33:0]                 r_prod;
    logic signed [33:0]                 r_acc;
    logic signed [lsvp_pkg::OUT_W-1:0]  r_left, r_right;

    // output register
    logic signed [lsvp_pkg::OUT_W-1:0]  r_o_left, r_o_right;
    logic                               r_o_play;
    logic [lsvp_pkg::POS_W-1:0]         r_o_pos;
    logic [lsvp_pkg::PASS_W-1:0]        r_o_pass;

    logic [lsvp_pkg::CUR_W-1:0]    end_val, over, loop_cur;
    logic [lsvp_pkg::POS_W-1:0]    loop_frame, idx, nxt, pos_clamp;
    logic [lsvp_pkg::POS_W:0]      idx_p1;
    logic [lsvp_pkg::PASS_W:0]     pass_p1;
    logic [lsvp_pkg::PASS_W-1:0]   pass_inc;
    logic                          finish, another, can_play, past_end;
    logic [29:0]                   gl_prod, gr_prod;
    logic signed [16:0]            diff;
    logic signed [33:0]            prod;
    logic signed [50:0]            pl, pr;
    logic [lsvp_pkg::ADDR_W-1:0]   ram_addr;
    logic [lsvp_pkg::SAMPLE_W-1:0] ram_rdata;

    // end of sample and loop point
    assign end_val    = {r_frame_count, {lsvp_pkg::FRAC_W{1'b0}}};
    assign past_end   = (r_cursor >= end_val);
    assign over       = r_cursor - end_val;
    assign loop_frame = ({1'b0, r_loop_start} < r_frame_count) ? {1'b0, r_loop_start} : '0;
    assign loop_cur   = {loop_frame, {lsvp_pkg::FRAC_W{1'b0}}} + over;
    assign can_play   = (r_frame_count != '0) && (r_step != '0);

    // saturating pass count and finish test
    assign pass_inc = (r_pass == lsvp_pkg::PASS_MAX) ? r_pass : r_pass + 1'b1;
    assign finish   = (r_loop_limit != '0) && (pass_inc >= r_loop_limit);
    assign pass_p1  = {1'b0, r_pass} + 1'b1;
    assign another  = (r_loop_limit == '0) || (pass_p1 < {1'b0, r_loop_limit});

    // current and next frame
    assign idx    = r_cursor[lsvp_pkg::CUR_W-1:lsvp_pkg::FRAC_W];
    assign idx_p1 = {1'b0, idx} + 1'b1;
    always_comb begin
        if (idx_p1 >= {1'b0, r_frame_count}) begin
            nxt = another ? loop_frame : idx;
        end else begin
            nxt = idx_p1[lsvp_pkg::POS_W-1:0];
        end
    end

    assign pos_clamp = (r_pos > r_frame_count) ? r_frame_count : r_pos;

    assign o_status.active   = r_active;
    assign o_status.can_play = can_play;
    assign o_status.past_end = past_end;

    // sample store
    always_comb begin
        if (i_cmd.ram_we) begin
            ram_addr = r_addr;
        end else if (i_cmd.rd_nxt) begin
            ram_addr = r_nxt;
        end else begin
            ram_addr = idx[lsvp_pkg::ADDR_W-1:0];
        end
    end

    lsvp_ram #(
        .WIDTH(lsvp_pkg::SAMPLE_W),
        .DEPTH(lsvp_pkg::SAMPLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_wdata),
        .o_rdata (ram_rdata)
    );

    // arithmetic
    assign gl_prod = r_gain_l[15:1] * r_master_l[15:1];
    assign gr_prod = r_gain_r[15:1] * r_master_r[15:1];
    assign diff    = $signed({ram_rdata[15], ram_rdata}) - $signed({r_s0[15], r_s0});
    assign prod    = diff * $signed({1'b0, r_f});
    assign pl      = r_acc * $signed({1'b0, r_gl});
    assign pr      = r_acc * $signed({1'b0, r_gr});

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= lsvp_pkg::STEP_RESET;
            r_frame_count <= '0;
            r_loop_start  <= '0;
            r_loop_limit  <= '0;
            r_gain_l      <= '0;
            r_gain_r      <= '0;
            r_master_l    <= lsvp_pkg::MASTER_RESET;
            r_master_r    <= lsvp_pkg::MASTER_RESET;
        end else if (i_cfg_valid) begin
            case (lsvp_pkg::t_reg_idx'(i_cfg_index))
                lsvp_pkg::REG_STEP_SIZE:    r_step        <= i_cfg_data[lsvp_pkg::STEP_W-1:0];
                lsvp_pkg::REG_FRAME_COUNT:  r_frame_count <= i_cfg_data[lsvp_pkg::POS_W-1:0];
                lsvp_pkg::REG_LOOP_START:   r_loop_start  <= i_cfg_data[lsvp_pkg::LOOP_W-1:0];
                lsvp_pkg::REG_LOOP_LIMIT:   r_loop_limit  <= i_cfg_data[lsvp_pkg::PASS_W-1:0];
                lsvp_pkg::REG_GAIN_LEFT:    r_gain_l      <= i_cfg_data[lsvp_pkg::GAIN_W-1:0];
                lsvp_pkg::REG_GAIN_RIGHT:   r_gain_r      <= i_cfg_data[lsvp_pkg::GAIN_W-1:0];
                lsvp_pkg::REG_MASTER_LEFT:  r_master_l    <= i_cfg_data[lsvp_pkg::GAIN_W-1:0];
                lsvp_pkg::REG_MASTER_RIGHT: r_master_r    <= i_cfg_data[lsvp_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // voice state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_active <= 1'b0;
            r_pass   <= '0;
            r_shown  <= '0;
        end else begin
            if (i_cmd.start) begin
                r_shown  <= pos_clamp;
                r_cursor <= {pos_clamp, {lsvp_pkg::FRAC_W{1'b0}}};
                r_active <= can_play;
                if (!r_active) begin
                    r_pass <= '0;
                end
            end
            if (i_cmd.stop || i_cmd.clr_active) begin
                r_active <= 1'b0;
            end
            if (i_cmd.end_pass) begin
                r_pass <= pass_inc;
                if (finish) begin
                    r_cursor <= end_val;
                    r_shown  <= r_frame_count;
                    r_active <= 1'b0;
                end else begin
                    r_cursor <= loop_cur;
                end
            end
            if (i_cmd.show) begin
                r_shown <= idx;
            end
            if (i_cmd.rd_nxt) begin
                r_cursor <= r_cursor + {{(lsvp_pkg::CUR_W - lsvp_pkg::STEP_W){1'b0}}, r_step};
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_addr  <= i_sample_address[lsvp_pkg::ADDR_W-1:0];
            r_wdata <= i_sample_value;
            r_pos   <= i_start_position;
            r_left  <= '0;
            r_right <= '0;
        end
        if (i_cmd.rd_cur) begin
            r_f   <= r_cursor[lsvp_pkg::FRAC_W-1:16];
            r_nxt <= nxt[lsvp_pkg::ADDR_W-1:0];
            r_gl  <= gl_prod[29:14];
            r_gr  <= gr_prod[29:14];
        end
        if (i_cmd.rd_nxt) begin
            r_s0 <= ram_rdata;
        end
        if (i_cmd.mul) begin
            r_prod <= prod;
        end
        if (i_cmd.acc) begin
            r_acc <= $signed({{2{r_s0[15]}}, r_s0, 16'b0}) + r_prod;
        end
        if (i_cmd.scale) begin
            r_left  <= pl[47:31];
            r_right <= pr[47:31];
        end
        if (i_cmd.load_out) begin
            r_o_left  <= r_left;
            r_o_right <= r_right;
            r_o_play  <= r_active;
            r_o_pos   <= r_shown;
            r_o_pass  <= r_pass;
        end
    end

    assign o_left_out       = r_o_left;
    assign o_right_out      = r_o_right;
    assign o_is_playing     = r_o_play;
    assign o_frame_position = r_o_pos;
    assign o_passes_done    = r_o_pass;

endmodule

// ----- hw/rtl/looping_sample_voice_player_top.sv -----
// looping_sample_voice_player_top: one looping sample-playback voice with linear interpolation
// depends on lsvp_pkg, lsvp_ctrl, lsvp_dpath (which holds lsvp_ram)
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------------------
//  in       | input     | i_in_valid / o_in_ready      | kind, sample address/value, start pos
//  out      | output    | o_out_valid / i_out_ready    | left/right out, playing, position, passes
//  cfg      | input     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// sequence: a sample write or a stop passes its own state and the final state; a tick on a
//   stopped voice settles and finishes; a start places and settles the cursor; a tick on a
//   playing voice settles, reads both frames, multiplies, accumulates, scales and settles
//   again after the cursor advance. the crossing loop in the controller handles one wrap per
//   cycle, and the two frames come through the single store port one after the other
// reset: synchronous, active low; the store is not cleared and needs no sweep after reset
// stalls: a finished result waits in the output register; the next item is taken meanwhile
//   and its result waits in the final state until the register is free
// config transfers are taken in every cycle (o_cfg_ready is tied high)
module looping_sample_voice_player_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [1:0]                            i_kind,
    input  logic [11:0]                           i_sample_address,
    input  logic signed [lsvp_pkg::SAMPLE_W-1:0]  i_sample_value,
    input  logic [lsvp_pkg::POS_W-1:0]            i_start_position,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [lsvp_pkg::OUT_W-1:0]     o_left_out,
    output logic signed [lsvp_pkg::OUT_W-1:0]     o_right_out,
    output logic                                  o_is_playing,
    output logic [lsvp_pkg::POS_W-1:0]            o_frame_position,
    output logic [lsvp_pkg::PASS_W-1:0]           o_passes_done,
    // configuration channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lsvp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lsvp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    lsvp_pkg::t_cmd    cmd;
    lsvp_pkg::t_status status;

    // registers live in the datapath and take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: one item at a time, steps the datapath through each kind
    lsvp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // cursor, sample store, interpolation and gain, plus the output register
    lsvp_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_valid      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample_address (i_sample_address),
        .i_sample_value   (i_sample_value),
        .i_start_position (i_start_position),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_is_playing     (o_is_playing),
        .o_frame_position (o_frame_position),
        .o_passes_done    (o_passes_done)
    );

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after a transfer");

    // frames are only read from a settled, playing cursor
    a_read_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_cur |-> (status.active && status.can_play && !status.past_end))
        else $error("frame read from an unsettled cursor");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten");

endmodule

// ----- sim/tb_looping_sample_voice_player_top.sv -----
// tb_looping_sample_voice_player_top: self-checking testbench of the looping sample voice
// predicts every result of the voice and compares it field by field; needs lsvp_pkg and
// looping_sample_voice_player_top
module tb_looping_sample_voice_player_top;
    import lsvp_pkg::*;

    localparam int IDLE_LIMIT    = 3000;  // cycles without any transfer before giving up
    localparam int HOLD_CYCLES   = 200;   // one long result-side hold-off
    localparam int SETTLE_CYCLES = 4;     // quiet cycles before a register update
    localparam int DRAIN_CYCLES  = 300;   // worst tick: ~256 end crossings plus the datapath
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 35;
    localparam int SAT_TICKS     = 270;   // 270 ticks of ~255 crossings pass 65535

    // playback state of the voice
    typedef struct packed {
        logic [63:0] cursor;    // 13.32 cursor, held wider
        logic        active;
        logic [15:0] passes;
        logic [12:0] shown;
    } voice_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
        logic                    playing;
        logic [POS_W-1:0]        position;
        logic [PASS_W-1:0]       passes;
    } frame_result_t;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic [POS_W-1:0]  frames;
        logic [LOOP_W-1:0] loop_at;
        logic [PASS_W-1:0] limit;
        logic [GAIN_W-1:0] gain_l;
        logic [GAIN_W-1:0] gain_r;
        logic [GAIN_W-1:0] mast_l;
        logic [GAIN_W-1:0] mast_r;
    } voice_setting_t;

    // voice predictor plus the queue of frames still owed by the block
    class voice_scoreboard;
        logic [STEP_W-1:0]       step;
        logic [POS_W-1:0]        frames;
        logic [LOOP_W-1:0]       loop_at;
        logic [PASS_W-1:0]       limit;
        logic [GAIN_W-1:0]       gain_l, gain_r, mast_l, mast_r;
        voice_t                  voice;
        logic signed [15:0]      store [SAMPLE_DEPTH];
        bit                      written [SAMPLE_DEPTH];
        frame_result_t           expected_frames [$];
        int                      items_seen, frames_played, checked, failures;

        function new();
            step    = STEP_RESET;
            frames  = '0;
            loop_at = '0;
            limit   = '0;
            gain_l  = '0;
            gain_r  = '0;
            mast_l  = MASTER_RESET;
            mast_r  = MASTER_RESET;
            voice   = '0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_STEP_SIZE:    step    = d[STEP_W-1:0];
                REG_FRAME_COUNT:  frames  = d[POS_W-1:0];
                REG_LOOP_START:   loop_at = d[LOOP_W-1:0];
                REG_LOOP_LIMIT:   limit   = d[PASS_W-1:0];
                REG_GAIN_LEFT:    gain_l  = d[GAIN_W-1:0];
                REG_GAIN_RIGHT:   gain_r  = d[GAIN_W-1:0];
                REG_MASTER_LEFT:  mast_l  = d[GAIN_W-1:0];
                REG_MASTER_RIGHT: mast_r  = d[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function bit playable();
            return frames != 0 && step != 0;
        endfunction

        // loop point falls back to frame zero when it is not inside the sample
        function logic [LOOP_W-1:0] loop_frame();
            return (loop_at < frames) ? loop_at : '0;
        endfunction

        function logic [15:0] gain_code(logic [15:0] g, logic [15:0] m);
            int unsigned t;
            t = ((32'(g) >> 1) * (32'(m) >> 1)) >> 14;
            return t[15:0];
        endfunction

        // one end crossing: wrap with overshoot, or finish on the last pass
        function bit cross_end(inout voice_t s);
            logic [63:0] end_c, over;
            end_c = {19'd0, frames, 32'd0};
            over  = (s.cursor >= end_c) ? s.cursor - end_c : 64'd0;
            if (s.passes != PASS_MAX) s.passes++;
            if (limit != 0 && s.passes >= limit) begin
                s.cursor = end_c;
                s.shown  = frames;
                s.active = 1'b0;
                return 1'b0;
            end
            s.cursor = {20'd0, loop_frame(), 32'd0} + over;
            return 1'b1;
        endfunction

        function bit settle(inout voice_t s);
            logic [63:0] end_c;
            if (!s.active) return 1'b0;
            if (!playable()) begin
                s.active = 1'b0;
                return 1'b0;
            end
            end_c = {19'd0, frames, 32'd0};
            while (s.active && s.cursor >= end_c)
                if (!cross_end(s)) break;
            if (s.active) s.shown = s.cursor[44:32];
            return s.active;
        endfunction

        // frame after idx; on the final pass the end frame repeats
        function int unsigned next_frame(voice_t s, int unsigned idx);
            bit another;
            if (idx + 1 < frames) return idx + 1;
            another = (limit == 0) || (32'(s.passes) + 1 < 32'(limit));
            return another ? 32'(loop_frame()) : idx;
        endfunction

        // which two store entries the next tick would read, if it plays
        function bit tick_frames(output int unsigned cur_i, output int unsigned nxt_i);
            voice_t s;
            s = voice;
            if (!settle(s)) return 1'b0;
            cur_i = s.cursor[44:32];
            nxt_i = next_frame(s, cur_i);
            return 1'b1;
        endfunction

        function void note_item(t_kind k, logic [11:0] addr, logic [15:0] value,
                                logic [POS_W-1:0] pos);
            frame_result_t     r;
            bit                was;
            logic [POS_W-1:0]  p;
            int unsigned       idx, nxt;
            logic signed [63:0] s0, s1, fr, interp, gl, gr, pl, pr;
            r = '0;
            items_seen++;
            case (k)
                KIND_WRITE: begin
                    store[addr]   = value;
                    written[addr] = 1'b1;
                end
                KIND_START: begin
                    was           = voice.active;
                    p             = (pos > frames) ? frames : pos;
                    voice.shown   = p;
                    voice.cursor  = {19'd0, p, 32'd0};
                    if (!was) voice.passes = '0;
                    voice.active  = playable();
                    void'(settle(voice));
                end
                KIND_STOP: voice.active = 1'b0;
                default: begin
                    if (settle(voice)) begin
                        idx    = voice.cursor[44:32];
                        nxt    = next_frame(voice, idx);
                        s0     = store[idx % SAMPLE_DEPTH];
                        s1     = store[nxt % SAMPLE_DEPTH];
                        fr     = {48'd0, voice.cursor[31:16]};
                        interp = s0 * 64'sd65536 + (s1 - s0) * fr;
                        gl     = {48'd0, gain_code(gain_l, mast_l)};
                        gr     = {48'd0, gain_code(gain_r, mast_r)};
                        // floor of the product over 2^31
                        pl     = (interp * gl) >>> 31;
                        pr     = (interp * gr) >>> 31;
                        r.left  = pl[OUT_W-1:0];
                        r.right = pr[OUT_W-1:0];
                        voice.cursor += {24'd0, step};
                        void'(settle(voice));
                        frames_played++;
                    end
                end
            endcase
            r.playing  = voice.active;
            r.position = voice.shown;
            r.passes   = voice.passes;
            expected_frames.push_back(r);
        endfunction

        function void check_result(logic [OUT_W-1:0] left, logic [OUT_W-1:0] right,
                                   logic playing, logic [POS_W-1:0] pos,
                                   logic [PASS_W-1:0] passes);
            frame_result_t want;
            checked++;
            if (expected_frames.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected", checked);
                return;
            end
            want = expected_frames.pop_front();
            if (want.left !== left || want.right !== right || want.playing !== playing ||
                want.position !== pos || want.passes !== passes) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result %0d: expected L %0d R %0d play %0b pos %0d passes %0d, %s",
                             checked, want.left, want.right, want.playing, want.position,
                             want.passes,
                             $sformatf("got L %0d R %0d play %0b pos %0d passes %0d",
                                       $signed(left), $signed(right), playing, pos, passes));
            end
        endfunction
    endclass

    // every input known from time zero
    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_in_valid       = 1'b0;
    logic [1:0]             i_kind           = KIND_STOP;
    logic [11:0]            i_sample_address = '0;
    logic [SAMPLE_W-1:0]    i_sample_value   = '0;
    logic [POS_W-1:0]       i_start_position = '0;
    logic                   i_out_ready      = 1'b0;
    logic                   i_cfg_valid      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index      = REG_STEP_SIZE;
    logic [CFG_DATA_W-1:0]  i_cfg_data       = '0;
    logic                   o_in_ready, o_out_valid, o_is_playing, o_cfg_ready;
    logic [OUT_W-1:0]       o_left_out, o_right_out;
    logic [POS_W-1:0]       o_frame_position;
    logic [PASS_W-1:0]      o_passes_done;

    voice_scoreboard sb;
    int  results_seen    = 0;
    int  settings_loaded = 0;
    int  stuck_cycles    = 0;
    int  steady_items    = 0;
    bit  calm            = 1'b0;  // last phase: no idling on either side
    bit  held_once       = 1'b0;

    looping_sample_voice_player_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_sample_address (i_sample_address),
        .i_sample_value   (i_sample_value),
        .i_start_position (i_start_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_left_out       (o_left_out),
        .o_right_out      (o_right_out),
        .o_is_playing     (o_is_playing),
        .o_frame_position (o_frame_position),
        .o_passes_done    (o_passes_done),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // result side: short random stalls, quiet stretches, and one long hold-off
    // that lets the block fill up while items keep coming
    initial begin : result_drain
        int idle_run, steady_cycles;
        idle_run      = 0;
        steady_cycles = 0;
        @(negedge i_clk);
        forever begin
            if (!held_once && !calm && results_seen >= 40) begin
                held_once = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                if (steady_cycles != 0) begin
                    steady_cycles--;
                end else if (idle_run == 0 && !calm) begin
                    if ($urandom_range(0, 39) == 0)
                        steady_cycles = $urandom_range(30, 80);
                    else if ($urandom_range(0, 5) == 0)
                        idle_run = $urandom_range(1, 4);
                end
                if (idle_run != 0) begin
                    i_out_ready <= 1'b0;
                    idle_run--;
                end else begin
                    i_out_ready <= 1'b1;
                end
                @(negedge i_clk);
            end
        end
    end

    // result transfers go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_left_out, o_right_out, o_is_playing, o_frame_position,
                            o_passes_done);
            results_seen++;
        end
    end

    // watchdog: too long without any transfer on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= IDLE_LIMIT) begin
            $display("no transfer for %0d cycles", stuck_cycles);
            $display("looping_sample_voice_player_top verification failed");
            $finish;
        end
    end

    // one item transfer; called and returns at a falling edge, valid left high
    task automatic send_item(t_kind k, logic [11:0] a, logic [15:0] s, logic [POS_W-1:0] p);
        if (calm || steady_items != 0) begin
            if (steady_items != 0) steady_items--;
        end else if ($urandom_range(0, 39) == 0) begin
            steady_items = $urandom_range(20, 60);
        end else if ($urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= k;
        i_sample_address <= a;
        i_sample_value   <= s;
        i_start_position <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(k, a, s, p);
        @(negedge i_clk);
    endtask

    // a tick, preceded by writes of any store entry it would read unwritten
    task automatic send_tick();
        int unsigned cur_i, nxt_i;
        if (sb.tick_frames(cur_i, nxt_i)) begin
            if (!sb.written[cur_i])
                send_item(KIND_WRITE, cur_i[11:0], 16'($urandom), 13'($urandom));
            if (!sb.written[nxt_i])
                send_item(KIND_WRITE, nxt_i[11:0], 16'($urandom), 13'($urandom));
        end
        send_item(KIND_TICK, 12'($urandom), 16'($urandom), 13'($urandom));
    endtask

    // register update on an idle block; all eight registers in one burst
    task automatic load_setting(voice_setting_t s);
        logic [CFG_DATA_W-1:0] vals [8];
        i_in_valid <= 1'b0;
        vals = '{s.step, 40'(s.frames), 40'(s.loop_at), 40'(s.limit),
                 40'(s.gain_l), 40'(s.gain_r), 40'(s.mast_l), 40'(s.mast_r)};
        while (sb.expected_frames.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        for (int i = 0; i < 8; i++) begin
            i_cfg_index <= t_reg_idx'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg(t_reg_idx'(i), vals[i]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic voice_setting_t random_setting();
        voice_setting_t s;
        s.step    = ($urandom_range(0, 3) == 0) ? {8'($urandom_range(0, 20)), 32'($urandom)}
                                                 : {6'd0, 2'($urandom_range(0, 2)), 32'($urandom)};
        s.frames  = 13'($urandom_range(1, 40));
        s.loop_at = 12'($urandom_range(0, s.frames + 4));
        s.limit   = 16'($urandom_range(0, 4));
        s.gain_l  = pick_gain();
        s.gain_r  = pick_gain();
        s.mast_l  = pick_gain();
        s.mast_r  = pick_gain();
        return s;
    endfunction

    // mostly starts followed by runs of ticks, with writes and stops mixed in; only ticks when ticks_only is set
    task automatic random_items(int count, bit ticks_only);
        int unsigned roll;
        logic [11:0] a;
        logic [15:0] s;
        logic [POS_W-1:0] p;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            a = (sb.frames == 0 || $urandom_range(0, 3) == 0) ? 12'($urandom)
                                                              : 12'($urandom_range(0, sb.frames - 1));
            case ($urandom_range(0, 11))
                0:       s = 16'h7FFF;
                1:       s = 16'h8000;
                2:       s = 16'hFFFF;
                default: s = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       p = 13'($urandom);
                1:       p = sb.frames;
                default: p = 13'($urandom_range(0, sb.frames));
            endcase
            if (ticks_only)
                send_tick();
            else if ((!sb.voice.active && roll < 50) || (roll >= 50 && roll < 58))
                send_item(KIND_START, a, s, p);
            else if (roll < 12)
                send_item(KIND_WRITE, a, s, p);
            else if (roll < 17)
                send_item(KIND_STOP, a, s, p);
            else
                send_tick();
        end
    endtask

    initial begin : stimulus
        voice_setting_t cfg;
        sb = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers leave the voice unplayable
        send_item(KIND_START, 12'hFFF, 16'hFFFF, 13'h1FFF);
        send_tick();
        send_item(KIND_STOP, 12'h000, 16'h0000, 13'h0000);

        // four frames, half-speed, loop back to frame 2, two passes
        cfg = '{step: 40'h00_8000_0000, frames: 13'd4, loop_at: 12'd2, limit: 16'd2,
                gain_l: 16'hFFFF, gain_r: 16'h1234, mast_l: 16'hFFFF, mast_r: 16'h0040};
        load_setting(cfg);
        send_item(KIND_WRITE, 12'd0, 16'h7FFF, 13'd0);
        send_item(KIND_WRITE, 12'd1, 16'h8000, 13'd0);
        send_item(KIND_WRITE, 12'd2, 16'h0000, 13'd0);
        send_item(KIND_WRITE, 12'd3, 16'hFFFF, 13'd0);
        send_item(KIND_WRITE, 12'hFFF, 16'h5A5A, 13'd0);
        // start at the end: crossing right away, wraps to the loop point
        send_item(KIND_START, 12'd0, 16'd0, 13'h1FFF);
        repeat (6) send_tick();                  // last pass ends, voice finishes
        send_tick();                             // finished voice gives silence
        send_item(KIND_START, 12'd0, 16'd0, 13'd1);
        send_tick();
        send_item(KIND_START, 12'd0, 16'd0, 13'd3);  // restart while playing keeps passes
        send_tick();
        send_item(KIND_STOP, 12'd0, 16'd0, 13'd0);
        send_tick();

        // random phases, the extremes among them
        load_setting(random_setting());
        random_items(PHASE_ITEMS, 1'b0);

        cfg = '{step: 40'd1, frames: 13'd4096, loop_at: 12'd4095, limit: 16'hFFFF,
                gain_l: pick_gain(), gain_r: pick_gain(), mast_l: 16'hFFFF, mast_r: 16'h0001};
        load_setting(cfg);
        random_items(PHASE_ITEMS, 1'b0);

        // zero step: starts stay stopped, a playing voice stops at its next tick
        cfg = '{step: 40'd0, frames: 13'd12, loop_at: 12'd3, limit: 16'd2,
                gain_l: 16'h8000, gain_r: 16'h8000, mast_l: 16'h8000, mast_r: 16'h8000};
        load_setting(cfg);
        random_items(PHASE_ITEMS / 2, 1'b0);

        // largest step over a single frame: ~256 wraps per tick until passes saturate
        cfg = '{step: 40'hFF_FFFF_FFFF, frames: 13'd1, loop_at: 12'd0, limit: 16'd0,
                gain_l: 16'hFFFF, gain_r: 16'h0000, mast_l: 16'hFFFF, mast_r: 16'hFFFF};
        load_setting(cfg);
        send_item(KIND_START, 12'($urandom), 16'($urandom), 13'd0);
        random_items(SAT_TICKS, 1'b1);

        // no frames at all
        cfg = '{step: STEP_RESET, frames: 13'd0, loop_at: 12'hFFF, limit: 16'd1,
                gain_l: pick_gain(), gain_r: pick_gain(), mast_l: pick_gain(), mast_r: pick_gain()};
        load_setting(cfg);
        random_items(PHASE_ITEMS / 2, 1'b0);

        // loop point not below frame count falls back to frame zero
        cfg = '{step: 40'h00_C000_0000, frames: 13'd10, loop_at: 12'd10, limit: 16'd3,
                gain_l: pick_gain(), gain_r: pick_gain(), mast_l: pick_gain(), mast_r: pick_gain()};
        load_setting(cfg);
        random_items(PHASE_ITEMS, 1'b0);

        repeat (2) begin
            load_setting(random_setting());
            random_items(PHASE_ITEMS, 1'b0);
        end

        // last phase runs at full rate on both sides
        load_setting(random_setting());
        calm = 1'b1;
        random_items(PHASE_ITEMS, 1'b0);

        i_in_valid <= 1'b0;
        while (sb.expected_frames.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        sb.failures += sb.expected_frames.size();

        $display("run covered %0d items, %0d played frames, %0d register settings",
                 sb.items_seen, sb.frames_played, settings_loaded);
        $display("%0d results compared, %0d failures", sb.checked, sb.failures);
        if (sb.failures == 0)
            $display("looping_sample_voice_player_top verification clean");
        else
            $display("looping_sample_voice_player_top verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lsvp_pkg.sv
hw/rtl/lsvp_ram.sv
hw/rtl/lsvp_ctrl.sv
hw/rtl/lsvp_dpath.sv
hw/rtl/looping_sample_voice_player_top.sv
sim/tb_looping_sample_voice_player_top.sv
